// ===== src/mkd2d_pkg.sv =====
// Shared types and constants for the 2-D Minkowski distance block.
`timescale 1ns / 1ps
`default_nettype none

package mkd2d_pkg;

  // Limb width of the serial multiplier (accumulator side).
  localparam int LIMB_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int ORDER_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO   = 2'd1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd2;
  localparam logic               GEO_RESET   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_POST,
    S_FINISH
  } state_t;

  // Which power is being built: dx^p, dy^p, or trial^p of the root search.
  typedef enum logic [1:0] {
    PH_X,
    PH_Y,
    PH_ROOT
  } phase_t;

  typedef struct packed {
    logic   capture;
    logic   load;
    logic   mul_step;
    logic   post;
    logic   out_load;
    phase_t phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run;
    logic pow_one;
    logic limb_last;
    logic mul_last;
    logic bit_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/minkowski_distance_2d_top.sv =====
// Top level of the 2-D integer-order Minkowski distance block.
//
// One request carries two points (in_first_x/y, in_second_x/y); it is taken
// when in_valid is high and in_stall is low. One result (out_distance,
// unsigned, FRAC_BITS fraction bits, floored) leaves per request when
// out_valid is high and out_stall is low. The user must write config (order,
// geography_present) through cfg_we / cfg_index / cfg_data only while the
// block is idle; the block itself does not enforce this. Work runs through
// one limb-serial multiplier: LIMB_BITS of the power accumulator times the
// multiplicand per cycle, over NLIMB = ceil(OUT_BITS * MAX_ORDER / 16) limbs.
// With geography absent or order zero, no power is built and the result is
// zero. One request is in work at a time; the next one can be taken once the
// prior result sits in the output register, even if that is still stalled.
// A stalled result holds; the block then waits before loading a newer one.
// Reset (rst_n, synchronous) empties the block and restores order 2 and
// geography present.
`timescale 1ns / 1ps
`default_nettype none

module minkowski_distance_2d_top
  import mkd2d_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int MAX_ORDER  = 4,
  parameter int FRAC_BITS  = 8,
  localparam int OUT_BITS  = COORD_BITS + 1 + FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] in_first_x,
  input  wire logic [COORD_BITS-1:0] in_first_y,
  input  wire logic [COORD_BITS-1:0] in_second_x,
  input  wire logic [COORD_BITS-1:0] in_second_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_BITS-1:0]        out_distance
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mkd2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mkd2d_datapath #(
    .COORD_BITS (COORD_BITS),
    .MAX_ORDER  (MAX_ORDER),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_first_x   (in_first_x),
    .in_first_y   (in_first_y),
    .in_second_x  (in_second_x),
    .in_second_y  (in_second_y),
    .cmd          (cmd),
    .stat         (stat),
    .out_distance (out_distance)
  );

endmodule

`default_nettype wire

// ===== src/mkd2d_datapath.sv =====
// Datapath: config registers, limb-serial power unit, target and root search.
`timescale 1ns / 1ps
`default_nettype none

module mkd2d_datapath
  import mkd2d_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int MAX_ORDER  = 4,
  parameter int FRAC_BITS  = 8,
  localparam int OUT_BITS  = COORD_BITS + 1 + FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [COORD_BITS-1:0] in_first_x,
  input  wire logic [COORD_BITS-1:0] in_first_y,
  input  wire logic [COORD_BITS-1:0] in_second_x,
  input  wire logic [COORD_BITS-1:0] in_second_y,
  input  wire ctrl_cmd_t             cmd,
  output dp_stat_t                   stat,
  output logic [OUT_BITS-1:0]        out_distance
);

  localparam int PW     = OUT_BITS * MAX_ORDER;
  localparam int NLIMB  = (PW + LIMB_BITS - 1) / LIMB_BITS;
  localparam int AW     = NLIMB * LIMB_BITS;
  localparam int LIDX_W = (NLIMB > 1) ? $clog2(NLIMB) : 1;
  localparam int P_W    = $clog2(MAX_ORDER + 1);
  localparam int SH_W   = $clog2(FRAC_BITS * MAX_ORDER + 2);
  localparam int PR_W   = LIMB_BITS + OUT_BITS;

  logic [ORDER_W-1:0]    order_r;
  logic                  geo_r;
  logic [P_W-1:0]        p_r;
  logic                  run_r;
  logic [COORD_BITS-1:0] dx_r, dy_r;
  logic [AW-1:0]         acc_r, sx_r, target_r;
  logic [OUT_BITS-1:0]   mcand_r;
  logic [OUT_BITS-1:0]   carry_r;
  logic [LIDX_W-1:0]     limb_r;
  logic [P_W-1:0]        mul_left_r;
  logic [OUT_BITS-1:0]   root_r, mask_r, dist_r;

  logic [COORD_BITS-1:0]     dx, dy;
  logic [OUT_BITS-1:0]       cand;
  logic [PR_W-1:0]           prod;
  logic [AW+LIMB_BITS-1:0]   rot;
  logic [AW-1:0]             sum;
  logic [SH_W-1:0]           shamt;
  logic [P_W-1:0]            p_sat;

  assign dx    = (in_first_x > in_second_x) ? in_first_x - in_second_x
                                            : in_second_x - in_first_x;
  assign dy    = (in_first_y > in_second_y) ? in_first_y - in_second_y
                                            : in_second_y - in_first_y;
  assign p_sat = (order_r > MAX_ORDER) ? P_W'(MAX_ORDER) : P_W'(order_r);

  assign cand  = root_r | mask_r;
  // One limb times the multiplicand, plus the carry from the limb below.
  assign prod  = PR_W'(acc_r[LIMB_BITS-1:0]) * PR_W'(mcand_r) + PR_W'(carry_r);
  // The accumulator rotates one limb per step; the new limb enters on top.
  assign rot   = {prod[LIMB_BITS-1:0], acc_r};
  assign sum   = sx_r + acc_r;
  assign shamt = SH_W'(FRAC_BITS * p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
      geo_r   <= GEO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER: order_r <= cfg_data[ORDER_W-1:0];
        CFG_GEO:   geo_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Counters and search mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limb_r     <= '0;
      mul_left_r <= '0;
      carry_r    <= '0;
      mask_r     <= '0;
    end else begin
      if (cmd.load) begin
        limb_r     <= '0;
        mul_left_r <= p_r - P_W'(1);
        carry_r    <= '0;
      end else if (cmd.mul_step) begin
        if (stat.limb_last) begin
          limb_r     <= '0;
          mul_left_r <= mul_left_r - P_W'(1);
          carry_r    <= '0;
        end else begin
          limb_r  <= limb_r + LIDX_W'(1);
          carry_r <= prod[PR_W-1:LIMB_BITS];
        end
      end
      if (cmd.post) begin
        case (cmd.phase)
          PH_Y:    mask_r <= {1'b1, {(OUT_BITS-1){1'b0}}};
          PH_ROOT: mask_r <= mask_r >> 1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx_r   <= dx;
      dy_r   <= dy;
      p_r    <= p_sat;
      run_r  <= geo_r && (order_r != '0);
      root_r <= '0;
    end
    if (cmd.load) begin
      case (cmd.phase)
        PH_X: begin
          acc_r   <= AW'(dx_r);
          mcand_r <= OUT_BITS'(dx_r);
        end
        PH_Y: begin
          acc_r   <= AW'(dy_r);
          mcand_r <= OUT_BITS'(dy_r);
        end
        default: begin
          acc_r   <= AW'(cand);
          mcand_r <= cand;
        end
      endcase
    end else if (cmd.mul_step) begin
      acc_r <= rot[AW+LIMB_BITS-1:LIMB_BITS];
    end
    if (cmd.post) begin
      case (cmd.phase)
        PH_X: sx_r     <= acc_r;
        PH_Y: target_r <= sum << shamt;
        default: begin
          if (acc_r <= target_r) root_r <= cand;
        end
      endcase
    end
    if (cmd.out_load) dist_r <= root_r;
  end

  assign stat.run       = run_r;
  assign stat.pow_one   = (p_r == P_W'(1));
  assign stat.limb_last = (limb_r == LIDX_W'(NLIMB - 1));
  assign stat.mul_last  = (mul_left_r == P_W'(1));
  assign stat.bit_last  = mask_r[0];
  assign out_distance   = dist_r;

  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(mask_r))
    else $error("search mask has more than one bit set");

  a_carry_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_step && stat.limb_last) |=> (carry_r == '0))
    else $error("carry not cleared at end of multiply pass");

  a_zero_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !run_r) |=> (dist_r == '0))
    else $error("nonzero distance with geography absent or order zero");

endmodule

`default_nettype wire

// ===== src/mkd2d_ctrl.sv =====
// Controller FSM: sequences powers, target build, root search and output.
`timescale 1ns / 1ps
`default_nettype none

module mkd2d_ctrl
  import mkd2d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd
);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOAD;
          phase_nxt = PH_X;
        end
      end
      S_LOAD: begin
        if (!stat.run)          state_nxt = S_FINISH;
        else if (stat.pow_one)  state_nxt = S_POST;
        else                    state_nxt = S_MUL;
      end
      S_MUL: begin
        if (stat.limb_last && stat.mul_last) state_nxt = S_POST;
      end
      S_POST: begin
        case (phase_r)
          PH_X: begin
            phase_nxt = PH_Y;
            state_nxt = S_LOAD;
          end
          PH_Y: begin
            phase_nxt = PH_ROOT;
            state_nxt = S_LOAD;
          end
          default: begin
            state_nxt = stat.bit_last ? S_FINISH : S_LOAD;
          end
        endcase
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.phase    = phase_r;
    in_stall     = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_LOAD:   cmd.load     = stat.run;
      S_MUL:    cmd.mul_step = 1'b1;
      S_POST:   cmd.post     = 1'b1;
      S_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("finished request not presented");

  a_mul_to_post: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && stat.limb_last && stat.mul_last) |=> (state_r == S_POST))
    else $error("power unit did not hand over after last multiply");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_LOAD && phase_r == PH_X))
    else $error("accepted request did not start with the x power");

endmodule

`default_nettype wire

// ===== bench/minkowski_distance_2d_top_tb.sv =====
// Self-checking bench for the 2-D Minkowski distance block.
`timescale 1ns / 1ps

module minkowski_distance_2d_top_tb;
  import mkd2d_pkg::*;

  localparam int COORD_W     = 16;
  localparam int FRAC_W      = 8;
  localparam int OUT_W       = COORD_W + 1 + FRAC_W;
  localparam int TOP_ORDER   = 4;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SIDE_SEND   = 0;
  localparam int SIDE_RECV   = 1;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 152;
  localparam int DIR_ROWS    = 22;

  // Indexes that map to no register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] ord_data;
    logic [CFG_DATA_W-1:0] geo_data;
    logic [COORD_W-1:0]    fx;
    logic [COORD_W-1:0]    fy;
    logic [COORD_W-1:0]    sx;
    logic [COORD_W-1:0]    sy;
    logic                  known;
    logic [OUT_W-1:0]      want_dist;
  } point_row_t;

  // Rows with known set carry the distance worked out by hand.
  localparam point_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{3'd2, 3'd1, 16'd0,     16'd0,     16'd0,     16'd0,     1'b1, 25'd0},
    '{3'd2, 3'd1, 16'd0,     16'd0,     16'd3,     16'd4,     1'b1, 25'd1280},
    '{3'd2, 3'd1, 16'd0,     16'd0,     16'd1,     16'd1,     1'b1, 25'd362},
    '{3'd2, 3'd1, 16'd65535, 16'd65535, 16'd0,     16'd0,     1'b0, 25'd0},
    '{3'd2, 3'd1, 16'd0,     16'd65535, 16'd65535, 16'd0,     1'b0, 25'd0},
    '{3'd1, 3'd1, 16'd0,     16'd0,     16'd65535, 16'd65535, 1'b1, 25'd33553920},
    '{3'd1, 3'd1, 16'd65535, 16'd0,     16'd0,     16'd65535, 1'b1, 25'd33553920},
    '{3'd1, 3'd1, 16'd1,     16'd0,     16'd0,     16'd0,     1'b1, 25'd256},
    '{3'd1, 3'd1, 16'd3,     16'd4,     16'd0,     16'd0,     1'b1, 25'd1792},
    '{3'd1, 3'd1, 16'd100,   16'd200,   16'd100,   16'd200,   1'b1, 25'd0},
    '{3'd3, 3'd1, 16'd0,     16'd0,     16'd65535, 16'd0,     1'b1, 25'd16776960},
    '{3'd3, 3'd1, 16'hAAAA,  16'h5555,  16'h5555,  16'hAAAA,  1'b0, 25'd0},
    '{3'd4, 3'd1, 16'd65535, 16'd65535, 16'd0,     16'd0,     1'b0, 25'd0},
    '{3'd4, 3'd1, 16'd0,     16'd0,     16'd0,     16'd1,     1'b1, 25'd256},
    '{3'd4, 3'd1, 16'd12345, 16'd54321, 16'd40000, 16'd7,     1'b0, 25'd0},
    '{3'd0, 3'd1, 16'd0,     16'd0,     16'd65535, 16'd65535, 1'b1, 25'd0},
    '{3'd5, 3'd1, 16'd65535, 16'd65535, 16'd0,     16'd0,     1'b0, 25'd0},
    '{3'd7, 3'd7, 16'd1,     16'd2,     16'd3,     16'd4,     1'b0, 25'd0},
    '{3'd6, 3'd1, 16'd777,   16'd0,     16'd0,     16'd999,   1'b0, 25'd0},
    '{3'd2, 3'd6, 16'd0,     16'd0,     16'd65535, 16'd65535, 1'b1, 25'd0},
    '{3'd2, 3'd0, 16'd5,     16'd5,     16'd9,     16'd9,     1'b1, 25'd0},
    '{3'd2, 3'd1, 16'd65535, 16'd0,     16'd65535, 16'd0,     1'b1, 25'd0}
  };

  localparam logic [CFG_DATA_W-1:0] ORDER_PLAN [PHASES] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd2, 3'd7, 3'd1, 3'd4, 3'd6, 3'd3
  };
  localparam logic GEO_PLAN [PHASES] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ORDER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_W-1:0]    in_first_x = '0;
  logic [COORD_W-1:0]    in_first_y = '0;
  logic [COORD_W-1:0]    in_second_x = '0;
  logic [COORD_W-1:0]    in_second_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_W-1:0]      out_distance;

  logic [ORDER_W-1:0] model_order = ORDER_RESET;
  logic               model_geo = GEO_RESET;
  logic [OUT_W-1:0]   dist_expect_q [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 calm_left [2] = '{0, 0};

  minkowski_distance_2d_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_first_x   (in_first_x),
    .in_first_y   (in_first_y),
    .in_second_x  (in_second_x),
    .in_second_y  (in_second_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Wait length per request; now and then a quiet run with no waits at all.
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left[side] = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [127:0] power_wide(input logic [OUT_W-1:0] base, input int p);
    logic [127:0] acc;
    logic [127:0] wide_base;
    acc = 128'd1;
    wide_base = {{(128 - OUT_W){1'b0}}, base};
    for (int k = 0; k < p; k++) acc = acc * wide_base;
    return acc;
  endfunction

  // Largest r with r^p <= (dx^p + dy^p) << (FRAC_W * p), searched top bit down.
  function automatic logic [OUT_W-1:0] minkowski_floor(
    input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
    input logic [COORD_W-1:0] bx, input logic [COORD_W-1:0] by,
    input logic [ORDER_W-1:0] ord, input logic geo);
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    int                 p;
    logic [127:0]       target;
    logic [OUT_W-1:0]   r;
    logic [OUT_W-1:0]   cand;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    p = (ord > TOP_ORDER) ? TOP_ORDER : int'(ord);
    r = '0;
    if (geo && p != 0) begin
      target = power_wide({{(OUT_W - COORD_W){1'b0}}, dx}, p)
             + power_wide({{(OUT_W - COORD_W){1'b0}}, dy}, p);
      target = target << (FRAC_W * p);
      for (int b = OUT_W - 1; b >= 0; b--) begin
        cand = r | ({{(OUT_W - 1){1'b0}}, 1'b1} << b);
        if (power_wide(cand, p) <= target) r = cand;
      end
    end
    return r;
  endfunction

  task automatic send_points(input logic [COORD_W-1:0] fx, input logic [COORD_W-1:0] fy,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic known, input logic [OUT_W-1:0] known_dist);
    int gap;
    gap = draw_wait(SIDE_SEND);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_first_x  <= fx;
    in_first_y  <= fy;
    in_second_x <= sx;
    in_second_y <= sy;
    do @(posedge clk); while (in_stall);
    if (known) dist_expect_q.push_back(known_dist);
    else dist_expect_q.push_back(minkowski_floor(fx, fy, sx, sy, model_order, model_geo));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (dist_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers, then the two unmapped indexes with junk.
  task automatic write_registers(input logic [CFG_DATA_W-1:0] ord_data,
                                 input logic [CFG_DATA_W-1:0] geo_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ORDER;
    cfg_data  <= ord_data;
    @(posedge clk);
    cfg_index <= CFG_GEO;
    cfg_data  <= geo_data;
    @(posedge clk);
    cfg_index <= CFG_UNUSED_2;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= CFG_UNUSED_3;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    model_order = ord_data;
    model_geo   = geo_data[0];
    @(posedge clk);
  endtask

  task automatic pick_points(output logic [COORD_W-1:0] fx, output logic [COORD_W-1:0] fy,
                             output logic [COORD_W-1:0] sx, output logic [COORD_W-1:0] sy);
    fx = COORD_W'($urandom);
    fy = COORD_W'($urandom);
    sx = COORD_W'($urandom);
    sy = COORD_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        sx = fx;
        sy = fy;
      end
      1: begin
        fx = $urandom_range(0, 1) ? '1 : '0;
        fy = $urandom_range(0, 1) ? '1 : '0;
        sx = $urandom_range(0, 1) ? '1 : '0;
        sy = $urandom_range(0, 1) ? '1 : '0;
      end
      2, 3: begin
        // Near neighbors; wrap at the edges gives large deltas now and then.
        sx = fx + COORD_W'($urandom_range(0, 32)) - COORD_W'(16);
        sy = fy + COORD_W'($urandom_range(0, 32)) - COORD_W'(16);
      end
      default: ;
    endcase
  endtask

  initial begin
    int hold;
    int want;
    forever begin
      hold = draw_wait(SIDE_RECV);
      if (hold > 0) begin
        out_stall <= 1'b1;
        // Half the time the stall lands on a result that is already waiting.
        if ($urandom_range(0, 1) == 1) do @(posedge clk); while (!out_valid);
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if (dist_expect_q.size() == 0) begin
        $display("%0t: result with no pending request, got %0d", $time, out_distance);
        mismatch_count++;
      end else begin
        want = dist_expect_q.pop_front();
        if (out_distance !== OUT_W'(want)) begin
          $display("%0t: distance mismatch: expected %0d, got %0d",
                   $time, want, out_distance);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] cur_ord;
    logic [CFG_DATA_W-1:0] cur_geo;
    logic [COORD_W-1:0]    fx;
    logic [COORD_W-1:0]    fy;
    logic [COORD_W-1:0]    sx;
    logic [COORD_W-1:0]    sy;
    point_row_t            row;
    cur_ord = ORDER_RESET;
    cur_geo = {{(CFG_DATA_W - 1){1'b0}}, GEO_RESET};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.ord_data != cur_ord || row.geo_data != cur_geo) begin
        drain_results();
        write_registers(row.ord_data, row.geo_data);
        cur_ord = row.ord_data;
        cur_geo = row.geo_data;
      end
      send_points(row.fx, row.fy, row.sx, row.sy, row.known, row.want_dist);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_registers(ORDER_PLAN[ph], {2'($urandom_range(0, 3)), GEO_PLAN[ph]});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick_points(fx, fy, sx, sy);
        send_points(fx, fy, sx, sy, 1'b0, '0);
        // Sender holds off mid-phase until the block has emptied.
        if (ph == 3 && i == PHASE_ITEMS / 2) drain_results();
      end
    end

    in_valid <= 1'b0;
    while (dist_expect_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
